// ===== rtl/aesrfs_pkg.sv =====
// shared types, constants and round functions for the aes round fixed-point search
package aesrfs_pkg;

    localparam int MAX_ROUNDS_BUILT = 64;
    localparam int NUM_STAGES       = MAX_ROUNDS_BUILT - 1;
    localparam int SEED_W           = 32;
    localparam int BLK_W            = 128;
    localparam int KEY_W            = 8;
    localparam int MAXR_W           = 7;
    localparam int COUNT_W          = 6;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 8;
    localparam int IN_DATA_W        = 32;
    localparam int OUT_DATA_W       = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROUNDS = 1'd1;

    localparam logic [KEY_W-1:0]  KEY_BYTE_RESET   = 8'd0;
    localparam logic [MAXR_W-1:0] MAX_ROUNDS_RESET = 7'd51;

    typedef struct packed {
        logic                 valid;
        logic [SEED_W-1:0]    seed;
        logic [BLK_W-1:0]     blk;
        logic                 hit;
        logic [COUNT_W-1:0]   count;
    } stage_t;

    typedef struct packed {
        logic [SEED_W-1:0]    seed;
        logic                 found;
        logic [COUNT_W-1:0]   count;
    } res_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] gf_double(input logic [7:0] v);
        gf_double = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // shiftrows, subbytes, mixcolumns, add round key; byte i at bits 8i+7:8i
    function automatic logic [BLK_W-1:0] enc_round(input logic [BLK_W-1:0] blk,
                                                   input logic [KEY_W-1:0] k);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [BLK_W-1:0] res;
        res = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[4*c+r] = SBOX[blk[8*(4*((c+r)%4)+r) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0  = t[4*c];
            a1  = t[4*c+1];
            a2  = t[4*c+2];
            a3  = t[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            res[8*(4*c)   +: 8] = a0 ^ all ^ gf_double(a0 ^ a1) ^ k;
            res[8*(4*c+1) +: 8] = a1 ^ all ^ gf_double(a1 ^ a2) ^ k;
            res[8*(4*c+2) +: 8] = a2 ^ all ^ gf_double(a2 ^ a3) ^ k;
            res[8*(4*c+3) +: 8] = a3 ^ all ^ gf_double(a3 ^ a0) ^ k;
        end
        enc_round = res;
    endfunction

endpackage

// ===== rtl/aesrfs_round_stage.sv =====
// one pipeline stage: one aes round plus the fixed-point compare for its round count
module aesrfs_round_stage
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [aesrfs_pkg::COUNT_W-1:0] round_idx,
    input  logic [aesrfs_pkg::KEY_W-1:0]   key_byte,
    input  logic [aesrfs_pkg::MAXR_W-1:0]  max_rounds,
    input  aesrfs_pkg::stage_t            stage_in,
    output aesrfs_pkg::stage_t            stage_out
);

    aesrfs_pkg::stage_t              stage_reg;
    aesrfs_pkg::stage_t              stage_next;
    logic [aesrfs_pkg::BLK_W-1:0]    blk_new;
    logic                            active;
    logic                            match;

    always_comb
    begin
        blk_new = aesrfs_pkg::enc_round(stage_in.blk, key_byte);
        active  = {1'b0, round_idx} < max_rounds;
        match   = active && (blk_new == {4{stage_in.seed}});
        stage_next.valid = stage_in.valid;
        stage_next.seed  = stage_in.seed;
        stage_next.blk   = blk_new;
        stage_next.hit   = stage_in.hit | match;
        if (stage_in.hit)
        begin
            stage_next.count = stage_in.count;
        end
        else if (match)
        begin
            stage_next.count = round_idx;
        end
        else
        begin
            stage_next.count = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// ===== rtl/aes_round_fixed_point_search_top.sv =====
// top level: config registers, round pipeline and output register with skid stage
// path: input transaction through the 63 round stage registers, then the output register, to m_tvalid
// throughput: one seed per cycle while the skid stage is empty; each stage holds one full aes round of 16 s-box lookups
// the pipeline stalls as one while the skid stage is full; no transaction is lost or repeated
// reset: rst_n asynchronous active low, clears valid bits, key_byte to 0, max_rounds to 51
// no memory to clear, so input is taken from the first cycle after reset
module aes_round_fixed_point_search_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [aesrfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aesrfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [aesrfs_pkg::IN_DATA_W-1:0]  s_tdata,   // seed_word[31:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [aesrfs_pkg::OUT_DATA_W-1:0] m_tdata    // seed_echo[31:0], found[32],
                                                         // round_count[38:33], zero[39]
);

    logic [aesrfs_pkg::KEY_W-1:0]  key_byte_reg;
    logic [aesrfs_pkg::MAXR_W-1:0] max_rounds_reg;

    aesrfs_pkg::stage_t stage_bus [aesrfs_pkg::NUM_STAGES+1];
    aesrfs_pkg::stage_t last_stage;
    aesrfs_pkg::res_t   last_res;

    logic               en;
    logic               out_valid_reg;
    logic               out_valid_next;
    aesrfs_pkg::res_t   out_data_reg;
    aesrfs_pkg::res_t   out_data_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    aesrfs_pkg::res_t   skid_data_reg;
    aesrfs_pkg::res_t   skid_data_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_byte_reg   <= aesrfs_pkg::KEY_BYTE_RESET;
            max_rounds_reg <= aesrfs_pkg::MAX_ROUNDS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aesrfs_pkg::CFG_KEY_BYTE:
                begin
                    key_byte_reg <= cfg_wdata[aesrfs_pkg::KEY_W-1:0];
                end
                aesrfs_pkg::CFG_MAX_ROUNDS:
                begin
                    max_rounds_reg <= cfg_wdata[aesrfs_pkg::MAXR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // stage zero: starting block from the incoming transaction
    assign stage_bus[0].valid = s_tvalid;
    assign stage_bus[0].seed  = s_tdata[aesrfs_pkg::SEED_W-1:0];
    assign stage_bus[0].blk   = {4{s_tdata[aesrfs_pkg::SEED_W-1:0]}};
    assign stage_bus[0].hit   = 1'b0;
    assign stage_bus[0].count = '0;

    for (genvar g = 1; g <= aesrfs_pkg::NUM_STAGES; g++)
    begin : g_round
        aesrfs_round_stage u_stage
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .round_idx  (aesrfs_pkg::COUNT_W'(g)),
            .key_byte   (key_byte_reg),
            .max_rounds (max_rounds_reg),
            .stage_in   (stage_bus[g-1]),
            .stage_out  (stage_bus[g])
        );
    end

    assign last_stage     = stage_bus[aesrfs_pkg::NUM_STAGES];
    assign last_res.seed  = last_stage.seed;
    assign last_res.found = last_stage.hit;
    assign last_res.count = last_stage.count;

    // output register with skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (en && last_stage.valid)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = last_res;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_data_next  = last_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg.count, out_data_reg.found, out_data_reg.seed};

`ifndef SYNTHESIS
    a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    a_skid_fill_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid stage filled without an output stall");

    a_count_zero_if_not_found : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.found |-> out_data_reg.count == '0)
        else $error("round count set without a hit");

    a_count_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.found |->
            out_data_reg.count != '0 && {1'b0, out_data_reg.count} < max_rounds_reg)
        else $error("hit reported outside the tried rounds");
`endif

endmodule
